// ===== hdl/wsd_pkg.sv =====
// shared types and constants for the websocket frame deframer
package wsd_pkg;

  // opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // 7-bit length codes
  localparam logic [6:0] LEN7_MAX   = 7'd125;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [30:0] LIMIT_MAX = 31'h7FFF_FFFF;

  // parse phases
  localparam logic [2:0] PH_HDR1    = 3'd0;
  localparam logic [2:0] PH_HDR2    = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // event codes
  localparam logic [2:0] EV_DATA  = 3'd0;
  localparam logic [2:0] EV_EMPTY = 3'd1;
  localparam logic [2:0] EV_PING  = 3'd2;
  localparam logic [2:0] EV_PONG  = 3'd3;
  localparam logic [2:0] EV_CLOSE = 3'd4;
  localparam logic [2:0] EV_ERROR = 3'd5;

  // error codes
  localparam logic [1:0] ERR_CTRL_EXT  = 2'd0;
  localparam logic [1:0] ERR_TOO_BIG   = 2'd1;
  localparam logic [1:0] ERR_NO_CONT   = 2'd2;
  localparam logic [1:0] ERR_UNKNOWN   = 2'd3;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic        message_is_text;
    logic        message_last;
    logic [15:0] close_code;
    logic [1:0]  error_code;
  } wsd_result_t;

endpackage

// ===== hdl/wsd_in_reg.sv =====
// input register for received bytes
module wsd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);
  import wsd_pkg::*;

  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= in_byte;
    end
  end
endmodule

// ===== hdl/wsd_parser.sv =====
// frame parse state and per-byte decode logic
module wsd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [30:0]         cfg_data,
  input  logic                step,
  input  logic [7:0]          b,
  output logic                res_valid,
  output wsd_pkg::wsd_result_t res
);
  import wsd_pkg::*;

  logic [30:0] max_bytes;
  logic [2:0]  parse_phase, parse_phase_next;
  logic        stopped, stopped_next;
  logic        frame_fin, frame_fin_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        frame_masked, frame_masked_next;
  logic        frame_long_len, frame_long_len_next;
  logic [3:0]  ext_bytes_left, ext_bytes_left_next;
  logic [63:0] frame_remaining, frame_remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_position, mask_position_next;
  logic [15:0] close_acc, close_acc_next;
  logic [1:0]  close_seen, close_seen_next;
  logic [30:0] message_bytes, message_bytes_next;
  logic        message_text, message_text_next;

  logic        hdr_done;
  logic        ctrl;
  logic        data_op;
  logic        known_op;
  logic [30:0] lim;
  logic [31:0] sum;
  logic        over;
  logic [7:0]  key_byte;
  logic [7:0]  d;
  logic        last_byte;
  logic [6:0]  len7;

  assign lim      = (max_bytes == '0) ? LIMIT_MAX : max_bytes;
  assign ctrl     = frame_opcode[3];
  assign data_op  = (frame_opcode == OP_CONT) || (frame_opcode == OP_TEXT) ||
                    (frame_opcode == OP_BINARY);
  assign known_op = data_op || (frame_opcode == OP_CLOSE) ||
                    (frame_opcode == OP_PING) || (frame_opcode == OP_PONG);
  assign len7     = b[6:0];

  always_comb begin
    unique case (mask_position)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign d         = b ^ key_byte;
  assign last_byte = (frame_remaining == 64'd1);

  always_comb begin
    parse_phase_next     = parse_phase;
    stopped_next         = stopped;
    frame_fin_next       = frame_fin;
    frame_opcode_next    = frame_opcode;
    frame_masked_next    = frame_masked;
    frame_long_len_next  = frame_long_len;
    ext_bytes_left_next  = ext_bytes_left;
    frame_remaining_next = frame_remaining;
    mask_key_next        = mask_key;
    mask_position_next   = mask_position;
    close_acc_next       = close_acc;
    close_seen_next      = close_seen;
    message_bytes_next   = message_bytes;
    message_text_next    = message_text;
    hdr_done             = 1'b0;
    res_valid            = 1'b0;
    res                  = '0;
    sum                  = '0;
    over                 = 1'b0;

    unique case (parse_phase)
      PH_HDR1: begin
        frame_fin_next    = b[7];
        frame_opcode_next = b[3:0];
        parse_phase_next  = PH_HDR2;
      end
      PH_HDR2: begin
        frame_masked_next    = b[7];
        mask_key_next        = '0;
        mask_position_next   = '0;
        frame_long_len_next  = len7 > LEN7_MAX;
        frame_remaining_next = {57'd0, len7};
        if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
          ext_bytes_left_next  = (len7 == LEN7_EXT16) ? 4'd2 : 4'd8;
          frame_remaining_next = '0;
          parse_phase_next     = PH_EXT;
        end else if (b[7]) begin
          parse_phase_next = PH_MASK;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_EXT: begin
        frame_remaining_next = {frame_remaining[55:0], b};
        ext_bytes_left_next  = ext_bytes_left - 4'd1;
        if (ext_bytes_left_next == '0) begin
          if (frame_masked) begin
            parse_phase_next = PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], b};
        if (mask_position != 2'd3) begin
          mask_position_next = mask_position + 2'd1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        mask_position_next   = mask_position + 2'd1;
        frame_remaining_next = frame_remaining - 64'd1;
        if (data_op) begin
          res_valid           = 1'b1;
          res.event_res       = EV_DATA;
          res.data_byte       = d;
          res.message_is_text = message_text;
          if (last_byte) begin
            parse_phase_next = PH_HDR1;
            res.message_last = frame_fin;
            if (frame_fin) begin
              message_bytes_next = '0;
            end
          end
        end else begin
          if (close_seen < 2'd2) begin
            close_acc_next  = {close_acc[7:0], d};
            close_seen_next = close_seen + 2'd1;
          end
          if (last_byte) begin
            parse_phase_next = PH_HDR1;
            res_valid        = 1'b1;
            if (frame_opcode == OP_PING) begin
              res.event_res = EV_PING;
            end else if (frame_opcode == OP_PONG) begin
              res.event_res = EV_PONG;
            end else begin
              res.event_res  = EV_CLOSE;
              res.close_code = (close_seen_next >= 2'd2) ? close_acc_next : '0;
            end
          end
        end
      end
      default: begin
        parse_phase_next = PH_HDR1;
      end
    endcase

    // header checks and frame setup
    if (hdr_done) begin
      sum  = {1'b0, message_bytes} + {1'b0, frame_remaining_next[30:0]};
      over = (frame_remaining_next[63:31] != '0) ||
             (frame_remaining_next[30:0] > lim) || (sum > {1'b0, lim});
      priority if (ctrl && frame_long_len_next) begin
        stopped_next   = 1'b1;
        res_valid      = 1'b1;
        res.event_res  = EV_ERROR;
        res.error_code = ERR_CTRL_EXT;
      end else if (!ctrl && over) begin
        stopped_next   = 1'b1;
        res_valid      = 1'b1;
        res.event_res  = EV_ERROR;
        res.error_code = ERR_TOO_BIG;
      end else if (!ctrl && frame_remaining_next != '0 && message_bytes != '0 &&
                   frame_opcode != OP_CONT) begin
        stopped_next   = 1'b1;
        res_valid      = 1'b1;
        res.event_res  = EV_ERROR;
        res.error_code = ERR_NO_CONT;
      end else if (!known_op) begin
        stopped_next   = 1'b1;
        res_valid      = 1'b1;
        res.event_res  = EV_ERROR;
        res.error_code = ERR_UNKNOWN;
      end else begin
        if (!ctrl) begin
          if (frame_opcode != OP_CONT) begin
            message_text_next = (frame_opcode == OP_TEXT);
          end
          message_bytes_next = sum[30:0];
        end
        mask_position_next = '0;
        close_acc_next     = '0;
        close_seen_next    = '0;
        if (frame_remaining_next == '0) begin
          // empty frame ends right at the header
          parse_phase_next = PH_HDR1;
          if (data_op) begin
            if (frame_fin) begin
              message_bytes_next  = '0;
              res_valid           = 1'b1;
              res.event_res       = EV_EMPTY;
              res.message_is_text = message_text_next;
              res.message_last    = 1'b1;
            end
          end else if (frame_opcode == OP_PING) begin
            res_valid     = 1'b1;
            res.event_res = EV_PING;
          end else if (frame_opcode == OP_PONG) begin
            res_valid     = 1'b1;
            res.event_res = EV_PONG;
          end else begin
            res_valid     = 1'b1;
            res.event_res = EV_CLOSE;
          end
        end else begin
          parse_phase_next = PH_PAYLOAD;
        end
      end
    end

    if (!step || stopped) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= LIMIT_MAX;
    end else if (cfg_write) begin
      max_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_HDR1;
      stopped         <= 1'b0;
      frame_fin       <= 1'b0;
      frame_opcode    <= '0;
      frame_masked    <= 1'b0;
      frame_long_len  <= 1'b0;
      ext_bytes_left  <= '0;
      frame_remaining <= '0;
      mask_key        <= '0;
      mask_position   <= '0;
      close_acc       <= '0;
      close_seen      <= '0;
      message_bytes   <= '0;
      message_text    <= 1'b0;
    end else if (step && !stopped) begin
      parse_phase     <= parse_phase_next;
      stopped         <= stopped_next;
      frame_fin       <= frame_fin_next;
      frame_opcode    <= frame_opcode_next;
      frame_masked    <= frame_masked_next;
      frame_long_len  <= frame_long_len_next;
      ext_bytes_left  <= ext_bytes_left_next;
      frame_remaining <= frame_remaining_next;
      mask_key        <= mask_key_next;
      mask_position   <= mask_position_next;
      close_acc       <= close_acc_next;
      close_seen      <= close_seen_next;
      message_bytes   <= message_bytes_next;
      message_text    <= message_text_next;
    end
  end
endmodule

// ===== hdl/wsd_out_reg.sv =====
// result register for deframer events
module wsd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  wsd_pkg::wsd_result_t res,
  input  logic                out_stall,
  output logic                out_valid,
  output wsd_pkg::wsd_result_t held
);
  import wsd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end
endmodule

// ===== hdl/websocket_frame_deframer_top.sv =====
// top level of the websocket receive-side frame deframer
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   in      | sink      | in_valid / in_stall | in_byte
//   out     | source    | out_valid/out_stall | event_res, data_byte, message_is_text,
//           |           |                     | message_last, close_code, error_code
//   cfg     | sink      | cfg_write           | cfg_data (max_message_bytes)
//
// one byte request per cycle sustained while the out port does not stall; a byte sits in the input
//   register while the parser decodes it, and its event, if any, is loaded into the result
//   register that drives the out port
// rst is synchronous, active high: parse state cleared, limit back to its maximum
// a stalled result holds the parser; the input register takes a byte while it is empty or
//   while its held byte is taken, else in_stall stays high until the parser takes the held byte
// after an error event the block drops every byte until reset
module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // events out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic        message_is_text,
  output logic        message_last,
  output logic [15:0] close_code,
  output logic [1:0]  error_code,
  // limit register
  input  logic        cfg_write,
  input  logic [30:0] cfg_data
);
  import wsd_pkg::*;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        take;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t held_res;

  // parser advances when a byte waits and the result register is free or draining
  assign take = held_valid && (!out_valid || !out_stall);

  wsd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsd_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (take),
    .b         (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // only bytes that raise an event load the result register
  wsd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .held      (held_res)
  );

  assign event_res       = held_res.event_res;
  assign data_byte       = held_res.data_byte;
  assign message_is_text = held_res.message_is_text;
  assign message_last    = held_res.message_last;
  assign close_code      = held_res.close_code;
  assign error_code      = held_res.error_code;
endmodule

// ===== hdl/wsd_checker.sv =====
// port-level checks for the deframer top level
module wsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  event_res,
  input logic [7:0]  data_byte,
  input logic        message_is_text,
  input logic        message_last,
  input logic [15:0] close_code,
  input logic [1:0]  error_code,
  input logic        cfg_write,
  input logic [30:0] cfg_data
);
  import wsd_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // data byte is zero on non-data events
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_DATA |-> data_byte == 8'd0)
    else $error("data byte set on non-data event");

  // error code only on error events
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_ERROR |-> error_code == 2'd0)
    else $error("error code set on non-error event");

  // nothing follows a delivered error
  a_err_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && event_res == EV_ERROR |=> !out_valid)
    else $error("result after error");
endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (.*);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the websocket frame deframer, byte stream in, events out
module tb_top;
  import wsd_pkg::*;

  // how the length of a generated frame is encoded in its header
  localparam int LEN_SHORT = 0;
  localparam int LEN_16    = 1;
  localparam int LEN_64    = 2;

  // cycles with no request taken on either side before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // cycles the block may still be busy after the last expected event
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic        message_is_text;
  logic        message_last;
  logic [15:0] close_code;
  logic [1:0]  error_code;
  logic        cfg_write = 1'b0;
  logic [30:0] cfg_data = 31'd0;

  websocket_frame_deframer_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_res       (event_res),
    .data_byte       (data_byte),
    .message_is_text (message_is_text),
    .message_last    (message_last),
    .close_code      (close_code),
    .error_code      (error_code),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // deframer state as the testbench sees it, advanced on every accepted byte
  // ---------------------------------------------------------------------------
  logic [2:0]  rx_phase;
  logic        rx_stopped;
  logic        rx_fin;
  logic [3:0]  rx_opcode;
  logic        rx_masked;
  logic [3:0]  rx_ext_left;
  logic [63:0] rx_remaining;
  logic [31:0] rx_key;
  logic [1:0]  rx_key_pos;      // key byte index, also counts key bytes in the header
  logic [15:0] rx_close_acc;
  logic [1:0]  rx_close_seen;
  logic [30:0] rx_msg_bytes;
  logic        rx_msg_text;
  logic        rx_long_len;     // 7-bit length said 126 or 127
  logic [30:0] msg_limit;

  // events still owed by the block, oldest first
  wsd_result_t expected_events[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;
  int events_checked = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  logic [1:0] final_error;

  task automatic reset_deframe_state();
    rx_phase = PH_HDR1;
    rx_stopped = 1'b0;
    rx_fin = 1'b0;
    rx_opcode = 4'h0;
    rx_masked = 1'b0;
    rx_ext_left = 4'd0;
    rx_remaining = 64'd0;
    rx_key = 32'd0;
    rx_key_pos = 2'd0;
    rx_close_acc = 16'd0;
    rx_close_seen = 2'd0;
    rx_msg_bytes = 31'd0;
    rx_msg_text = 1'b0;
    rx_long_len = 1'b0;
    msg_limit = LIMIT_MAX;
  endtask

  // a limit of zero means the largest limit, LIMIT_MAX
  function automatic logic [30:0] eff_limit();
    return (msg_limit == 31'd0) ? LIMIT_MAX : msg_limit;
  endfunction

  function automatic logic is_data_op(input logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BINARY;
  endfunction

  task automatic push_event(input logic [2:0] ev, input logic [7:0] d, input logic text,
                            input logic last, input logic [15:0] code, input logic [1:0] err);
    wsd_result_t r;
    r.event_res = ev;
    r.data_byte = d;
    r.message_is_text = text;
    r.message_last = last;
    r.close_code = code;
    r.error_code = err;
    expected_events.push_back(r);
  endtask

  // any error freezes the parser until reset
  task automatic raise_error(input logic [1:0] err);
    rx_stopped = 1'b1;
    push_event(EV_ERROR, 8'h00, 1'b0, 1'b0, 16'h0000, err);
  endtask

  task automatic end_frame(input logic has_byte, input logic [7:0] d);
    rx_phase = PH_HDR1;
    if (is_data_op(rx_opcode)) begin
      if (rx_fin) rx_msg_bytes = 31'd0;
      if (has_byte) push_event(EV_DATA, d, rx_msg_text, rx_fin, 16'h0000, 2'd0);
      else if (rx_fin) push_event(EV_EMPTY, 8'h00, rx_msg_text, 1'b1, 16'h0000, 2'd0);
    end else if (rx_opcode == OP_PING) begin
      push_event(EV_PING, 8'h00, 1'b0, 1'b0, 16'h0000, 2'd0);
    end else if (rx_opcode == OP_PONG) begin
      push_event(EV_PONG, 8'h00, 1'b0, 1'b0, 16'h0000, 2'd0);
    end else begin
      push_event(EV_CLOSE, 8'h00, 1'b0, 1'b0,
                 (rx_close_seen >= 2'd2) ? rx_close_acc : 16'h0000, 2'd0);
    end
  endtask

  // checks made once the whole header is in, in priority order
  task automatic close_header();
    logic        ctrl;
    logic [63:0] lim;
    ctrl = rx_opcode >= OP_CLOSE;
    lim = 64'(eff_limit());
    if (ctrl && rx_long_len) begin
      raise_error(ERR_CTRL_EXT);
      return;
    end
    if (!ctrl) begin
      if (rx_remaining > lim || 64'(rx_msg_bytes) + rx_remaining > lim) begin
        raise_error(ERR_TOO_BIG);
        return;
      end
      if (rx_remaining != 64'd0 && rx_msg_bytes != 31'd0 && rx_opcode != OP_CONT) begin
        raise_error(ERR_NO_CONT);
        return;
      end
    end
    if (!is_data_op(rx_opcode) && rx_opcode != OP_CLOSE && rx_opcode != OP_PING &&
        rx_opcode != OP_PONG) begin
      raise_error(ERR_UNKNOWN);
      return;
    end
    if (!ctrl) begin
      if (rx_opcode != OP_CONT) rx_msg_text = (rx_opcode == OP_TEXT);
      rx_msg_bytes = 31'(64'(rx_msg_bytes) + rx_remaining);
    end
    rx_key_pos = 2'd0;
    rx_close_acc = 16'h0000;
    rx_close_seen = 2'd0;
    if (rx_remaining == 64'd0) end_frame(1'b0, 8'h00);
    else rx_phase = PH_PAYLOAD;
  endtask

  // advance the expected parser by one accepted byte, queueing any event it causes
  task automatic deframe_byte(input logic [7:0] b);
    logic [6:0] len7;
    logic [7:0] d;
    if (rx_stopped) return;
    case (rx_phase)
      PH_HDR1: begin
        rx_fin = b[7];
        rx_opcode = b[3:0];
        rx_phase = PH_HDR2;
      end
      PH_HDR2: begin
        len7 = b[6:0];
        rx_masked = b[7];
        rx_key = 32'd0;
        rx_key_pos = 2'd0;
        rx_long_len = len7 > LEN7_MAX;
        if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
          rx_ext_left = (len7 == LEN7_EXT16) ? 4'd2 : 4'd8;
          rx_remaining = 64'd0;
          rx_phase = PH_EXT;
        end else begin
          rx_remaining = 64'(len7);
          if (rx_masked) rx_phase = PH_MASK;
          else close_header();
        end
      end
      PH_EXT: begin
        rx_remaining = {rx_remaining[55:0], b};
        rx_ext_left = rx_ext_left - 4'd1;
        if (rx_ext_left == 4'd0) begin
          if (rx_masked) rx_phase = PH_MASK;
          else close_header();
        end
      end
      PH_MASK: begin
        rx_key = {rx_key[23:0], b};
        if (rx_key_pos != 2'd3) rx_key_pos = rx_key_pos + 2'd1;
        else close_header();
      end
      PH_PAYLOAD: begin
        // key byte 0 is the first key byte received, the top one of rx_key
        d = b ^ rx_key[8 * (3 - int'(rx_key_pos)) +: 8];
        rx_key_pos = rx_key_pos + 2'd1;
        rx_remaining = rx_remaining - 64'd1;
        if (is_data_op(rx_opcode)) begin
          if (rx_remaining == 64'd0) end_frame(1'b1, d);
          else push_event(EV_DATA, d, rx_msg_text, 1'b0, 16'h0000, 2'd0);
        end else begin
          if (rx_close_seen < 2'd2) begin
            rx_close_acc = {rx_close_acc[7:0], d};
            rx_close_seen = rx_close_seen + 2'd1;
          end
          if (rx_remaining == 64'd0) end_frame(1'b0, 8'h00);
        end
      end
      default: rx_phase = PH_HDR1;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driving side
  // ---------------------------------------------------------------------------

  // send one byte request; called at a rising edge, returns at the edge that took it
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    // stall is settled by the falling edge and holds until the next rising one
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_stream(input logic [7:0] bytes_q[$]);
    foreach (bytes_q[i]) push_byte(bytes_q[i]);
  endtask

  // build one frame with random reserved bits, key and payload, then send it
  task automatic send_frame(input logic fin, input logic [3:0] opc, input logic masked,
                            input int unsigned len, input int form);
    logic [7:0]  s[$];
    logic [31:0] key;
    logic [63:0] len64;
    key = $urandom;
    len64 = 64'(len);
    s.push_back({fin, 3'($urandom_range(7)), opc});
    case (form)
      LEN_SHORT: s.push_back({masked, len64[6:0]});
      LEN_16: begin
        s.push_back({masked, LEN7_EXT16});
        s.push_back(len64[15:8]);
        s.push_back(len64[7:0]);
      end
      default: begin
        s.push_back({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) s.push_back(len64[8 * i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) s.push_back(key[8 * i +: 8]);
    repeat (len) s.push_back(8'($urandom));
    send_stream(s);
  endtask

  function automatic logic [3:0] random_control_op();
    case ($urandom_range(2))
      0:       return OP_CLOSE;
      1:       return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  // one well-formed frame that fits the open message and the current limit
  task automatic random_frame();
    int unsigned k;
    int unsigned len;
    longint      cap;
    longint      top;
    logic [3:0]  opc;
    logic        masked;
    int          form;
    masked = 1'($urandom_range(1));
    cap = longint'(eff_limit()) - longint'(rx_msg_bytes);
    if (cap < 0) cap = 0;
    k = $urandom_range(99);
    if (k < 22) begin
      // control frames: mostly short, a few up to the 7-bit maximum
      len = ($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(4);
      send_frame(1'($urandom_range(1)), random_control_op(), masked, len, LEN_SHORT);
    end else begin
      if (rx_msg_bytes != 31'd0) begin
        // a message is open: continue it, or an empty new-opcode frame now and then
        if ($urandom_range(9) == 0) opc = $urandom_range(1) ? OP_TEXT : OP_BINARY;
        else opc = OP_CONT;
      end else begin
        k = $urandom_range(9);
        if (k == 0) opc = OP_CONT;           // continuation with nothing open
        else if (k < 6) opc = OP_TEXT;
        else opc = OP_BINARY;
      end
      k = $urandom_range(99);
      top = (k < 70) ? 12 : (k < 92) ? 125 : 400;
      if (opc != OP_CONT && rx_msg_bytes != 31'd0) top = 0;
      if (top > cap) top = cap;
      len = $urandom_range(top);
      k = $urandom_range(19);
      if (len > 125) form = (k < 4) ? LEN_64 : LEN_16;
      else form = (k < 17) ? LEN_SHORT : (k < 19) ? LEN_16 : LEN_64;
      send_frame($urandom_range(9) < 6, opc, masked, len, form);
    end
  endtask

  // drop valid, let every owed event come out, then give the block time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while idle
  task automatic write_limit(input logic [30:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    msg_limit = v;
  endtask

  task automatic run_random(input int sender_pct, input int recv_pct, input logic do_write,
                            input logic [30:0] lim, input int nbytes);
    int target;
    wait_idle();
    if (do_write) write_limit(lim);
    send_idle_pct = sender_pct;
    recv_stall_pct = recv_pct;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) random_frame();
    // close any open message so the next limit never sees a leftover count
    if (rx_msg_bytes != 31'd0) send_frame(1'b1, OP_CONT, 1'b0, 0, LEN_SHORT);
  endtask

  // ---------------------------------------------------------------------------
  // receiving side
  // ---------------------------------------------------------------------------

  // random stall on the event port, decided at each rising edge
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // an event is taken at the next rising edge when valid and no stall at the falling one
  wsd_result_t want_ev;
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual event %0d data %0h err %0d",
                 $time, event_res, data_byte, error_code);
        fail_count++;
      end else begin
        want_ev = expected_events.pop_front();
        check_field("event_res", 16'(want_ev.event_res), 16'(event_res));
        check_field("data_byte", 16'(want_ev.data_byte), 16'(data_byte));
        check_field("message_is_text", 16'(want_ev.message_is_text), 16'(message_is_text));
        check_field("message_last", 16'(want_ev.message_last), 16'(message_last));
        check_field("close_code", want_ev.close_code, close_code);
        check_field("error_code", 16'(want_ev.error_code), 16'(error_code));
        events_checked++;
      end
    end
  end

  // hang detector: counts cycles in which neither port takes a request
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d events still owed",
                 $time, quiet_cycles, expected_events.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // unmasked text with the extreme byte values, then a masked one-byte binary frame
  task automatic test_plain_frames();
    logic [7:0] s[$];
    s = '{8'h81, 8'h02, 8'h00, 8'hFF,
          8'h82, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF};
    send_stream(s);
  endtask

  // empty text end with all reserved bits set, ping, close with a code,
  // close too short for a code, empty pong
  task automatic test_control_frames();
    logic [7:0] s[$];
    s = '{8'hF1, 8'h00,
          8'h89, 8'h00,
          8'h88, 8'h02, 8'h03, 8'hE8,
          8'h88, 8'h01, 8'h07,
          8'h8A, 8'h00};
    send_stream(s);
  endtask

  // 16-bit length on an unfinished binary fragment, empty 64-bit continuation,
  // then an empty final continuation that ends the message
  task automatic test_extended_lengths();
    logic [7:0] s[$];
    s = '{8'h02, 8'h7E, 8'h00, 8'h01, 8'hC3,
          8'h00, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h80, 8'h00};
    send_stream(s);
  endtask

  task automatic test_random_no_idle();
    run_random(0, 0, 1'b0, LIMIT_MAX, 300);
  endtask

  // zero limit behaves as the largest one
  task automatic test_random_sender_idle();
    run_random(50, 0, 1'b1, 31'd0, 350);
  endtask

  task automatic test_random_receiver_stall();
    run_random(0, 50, 1'b1, 31'($urandom_range(300, 20)), 350);
  endtask

  // smallest and largest limit with gaps on both sides
  task automatic test_random_both_idle();
    run_random(17, 17, 1'b1, 31'd1, 200);
    run_random(17, 17, 1'b1, LIMIT_MAX, 350);
  endtask

  // an error freezes the block until reset, so only one kind is taken per run,
  // followed by noise that must produce nothing
  task automatic test_error_stop();
    logic [30:0] lim;
    int unsigned pick;
    wait_idle();
    final_error = 2'($urandom_range(3));
    case (final_error)
      ERR_CTRL_EXT: begin
        send_frame(1'b1, random_control_op(), 1'($urandom_range(1)), 0,
                   $urandom_range(1) ? LEN_16 : LEN_64);
      end
      ERR_TOO_BIG: begin
        lim = 31'($urandom_range(8, 1));
        write_limit(lim);
        send_frame(1'b1, OP_BINARY, 1'($urandom_range(1)), lim + $urandom_range(4, 1),
                   LEN_SHORT);
      end
      ERR_NO_CONT: begin
        send_frame(1'b0, OP_TEXT, 1'b0, 3, LEN_SHORT);
        send_frame(1'b1, OP_BINARY, 1'($urandom_range(1)), 2, LEN_SHORT);
      end
      default: begin
        // reserved opcodes, from both the data and the control range
        pick = $urandom_range(12, 3);
        send_frame(1'b1, (pick < 8) ? 4'(pick) : 4'(pick + 3), 1'($urandom_range(1)),
                   $urandom_range(3), LEN_SHORT);
      end
    endcase
    repeat (12) push_byte(8'($urandom));
  endtask

  initial begin
    reset_deframe_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_plain_frames();
    test_control_frames();
    test_extended_lengths();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_error_stop();
    wait_idle();
    $display("covered %0d stream bytes and %0d checked events under five limit/idle settings",
             bytes_sent, events_checked);
    $display("the run closed on error code %0d, with the stream ignored after it",
             final_error);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wsd_pkg.sv
hdl/wsd_in_reg.sv
hdl/wsd_parser.sv
hdl/wsd_out_reg.sv
hdl/websocket_frame_deframer_top.sv
hdl/wsd_checker.sv
tb/sv/tb_top.sv
